// ===== rtl/bfi_pkg.sv =====
// Package for the byte-code interpreter: types, constants and the opcode table.
package bfi_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PROG_DEPTH = 256;
  localparam int unsigned PA_W       = $clog2(PROG_DEPTH);
  localparam int unsigned PC_W       = PA_W + 1;
  localparam int unsigned MEM_DEPTH  = 256;
  localparam int unsigned DA_W       = $clog2(MEM_DEPTH);
  localparam int unsigned Q_DEPTH    = 64;
  localparam int unsigned QA_W       = $clog2(Q_DEPTH);
  localparam int unsigned QC_W       = QA_W + 1;

  localparam logic [BYTE_W-1:0] CH_HALT  = 8'h00;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_LB    = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RB    = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_IO    = 8'h3F;

  localparam logic [BYTE_W-1:0] MODE_COPY   = 8'd6;
  localparam logic [BYTE_W-1:0] MODE_PUSH   = 8'd8;
  localparam logic [BYTE_W-1:0] MODE_POPB   = 8'd9;
  localparam logic [BYTE_W-1:0] MODE_POPF   = 8'd10;
  localparam logic [BYTE_W-1:0] MODE_QCLR   = 8'd11;
  localparam logic [BYTE_W-1:0] MODE_LOWER  = 8'd12;
  localparam logic [BYTE_W-1:0] MODE_UPPER  = 8'd13;
  localparam logic [BYTE_W-1:0] MODE_DIGIT  = 8'd14;
  localparam logic [BYTE_W-1:0] MODE_OPCODE = 8'd15;
  localparam logic [BYTE_W-1:0] MODE_AND    = 8'd20;
  localparam logic [BYTE_W-1:0] MODE_OR     = 8'd21;
  localparam logic [BYTE_W-1:0] MODE_NZ     = 8'd22;
  localparam logic [BYTE_W-1:0] MODE_XOR    = 8'd23;
  localparam logic [BYTE_W-1:0] MODE_RDDP   = 8'd24;
  localparam logic [BYTE_W-1:0] MODE_RDPC   = 8'd25;
  localparam logic [BYTE_W-1:0] MODE_JBACK  = 8'd26;
  localparam logic [BYTE_W-1:0] MODE_JFWD   = 8'd27;

  localparam logic [BYTE_W-1:0] OFS_LOWER   = 8'd97;
  localparam logic [BYTE_W-1:0] OFS_UPPER   = 8'd65;
  localparam logic [BYTE_W-1:0] OFS_DIGIT   = 8'd48;
  localparam logic [BYTE_W-1:0] LIM_LETTER  = 8'd25;
  localparam logic [BYTE_W-1:0] LIM_DIGIT   = 8'd9;
  localparam logic [BYTE_W-1:0] LIM_OPCODE  = 8'd7;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_EXEC    = 2'd1,
    REQ_RESTART = 2'd2
  } req_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [PA_W-1:0]   prog_addr;
    logic [BYTE_W-1:0] prog_byte;
  } in_t;

  typedef struct packed {
    logic              running;
    logic [PC_W-1:0]   program_counter;
    logic [DA_W-1:0]   data_pointer;
    logic [BYTE_W-1:0] cell_value;
    logic [BYTE_W-1:0] current_mode;
    logic [QC_W-1:0]   queue_fill;
  } out_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_ACCEPT, CMD_LOAD, CMD_RESTART, CMD_HALT, CMD_DECODE, CMD_EXEC,
    CMD_SCANF_INIT, CMD_SCANF_RD, CMD_SCANF_CHK,
    CMD_SCANB_INIT, CMD_SCANB_DEC, CMD_SCANB_RD, CMD_SCANB_CHK,
    CMD_COPY_INIT, CMD_COPY_RD, CMD_COPY_CHK,
    CMD_POPB_RD, CMD_POPB_WR, CMD_POPF_RD, CMD_POPF_WR, CMD_ADVANCE
  } cmd_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_RESTART, ST_FETCH, ST_DECODE, ST_EXEC, ST_HALT,
    ST_SCANF_INIT, ST_SCANF_RD, ST_SCANF_CHK,
    ST_SCANB_INIT, ST_SCANB_DEC, ST_SCANB_RD, ST_SCANB_CHK,
    ST_COPY_INIT, ST_COPY_RD, ST_COPY_CHK,
    ST_POPB_RD, ST_POPB_WR, ST_POPF_RD, ST_POPF_WR, ST_ADVANCE,
    ST_SETTLE, ST_OUT
  } state_e;

  typedef struct packed {
    logic              stop;
    logic              done;
    logic              cell_zero;
    logic [BYTE_W-1:0] instr;
    logic [BYTE_W-1:0] mode;
  } ctl_sts_t;

  function automatic logic [BYTE_W-1:0] op_code(input logic [2:0] idx);
    logic [BYTE_W-1:0] r;
    case (idx)
      3'd0:    r = CH_PLUS;
      3'd1:    r = CH_MINUS;
      3'd2:    r = CH_LEFT;
      3'd3:    r = CH_RIGHT;
      3'd4:    r = CH_LB;
      3'd5:    r = CH_RB;
      3'd6:    r = CH_EQ;
      default: r = CH_IO;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/bf_style_interpreter_step.sv =====
// Top level of the stepping byte-code interpreter.
// One transaction is taken when start is high and busy is low; busy then stays high until
// the single result has been shown for one cycle with result_valid_o, which the receiver
// must take as it comes. A load or restart passes through its own state, then SETTLE and OUT;
// a plain instruction through FETCH, DECODE, EXEC, SETTLE and OUT; and a queue pop through
// FETCH, DECODE, a read and a write state, ADVANCE, SETTLE and OUT. The program, data and
// queue RAMs all have registered reads. Forward and backward bracket scans and the program
// copy walk the program RAM one address at a time. Restart clears the data store at once
// through per-cell valid bits.
module bf_style_interpreter_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bfi_pkg::in_t  req_i,
  output logic          result_valid_o,
  output bfi_pkg::out_t result_o
);

  bfi_pkg::cmd_e     cmd;
  bfi_pkg::ctl_sts_t sts;

  bfi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_type_i (req_i.req_type),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy),
    .strobe_o   (result_valid_o)
  );

  bfi_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .sts_o  (sts),
    .res_o  (result_o)
  );

endmodule

// ===== rtl/bfi_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bfi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bfi_ctrl.sv =====
// Sequencer for the interpreter: request dispatch, scans, queue operations.
module bfi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        req_type_i,
  input  bfi_pkg::ctl_sts_t sts_i,
  output bfi_pkg::cmd_e     cmd_o,
  output logic              busy_o,
  output logic              strobe_o
);

  bfi_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfi_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cmd_o    = bfi_pkg::CMD_NONE;
    busy_o   = 1'b1;
    strobe_o = 1'b0;
    case (state_q)
      bfi_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o = bfi_pkg::CMD_ACCEPT;
          case (bfi_pkg::req_e'(req_type_i))
            bfi_pkg::REQ_LOAD:    state_d = bfi_pkg::ST_LOAD;
            bfi_pkg::REQ_EXEC:    state_d = bfi_pkg::ST_FETCH;
            bfi_pkg::REQ_RESTART: state_d = bfi_pkg::ST_RESTART;
            default:              state_d = bfi_pkg::ST_SETTLE;
          endcase
        end
      end
      bfi_pkg::ST_LOAD: begin
        cmd_o   = bfi_pkg::CMD_LOAD;
        state_d = bfi_pkg::ST_SETTLE;
      end
      bfi_pkg::ST_RESTART: begin
        cmd_o   = bfi_pkg::CMD_RESTART;
        state_d = bfi_pkg::ST_SETTLE;
      end
      bfi_pkg::ST_FETCH: begin
        state_d = sts_i.stop ? bfi_pkg::ST_HALT : bfi_pkg::ST_DECODE;
      end
      bfi_pkg::ST_DECODE: begin
        cmd_o   = bfi_pkg::CMD_DECODE;
        state_d = bfi_pkg::ST_EXEC;
        if (sts_i.instr == bfi_pkg::CH_HALT) begin
          state_d = bfi_pkg::ST_HALT;
        end else if (sts_i.instr == bfi_pkg::CH_LB && sts_i.cell_zero) begin
          state_d = bfi_pkg::ST_SCANF_INIT;
        end else if (sts_i.instr == bfi_pkg::CH_RB && !sts_i.cell_zero) begin
          state_d = bfi_pkg::ST_SCANB_INIT;
        end else if (sts_i.instr == bfi_pkg::CH_IO) begin
          if (sts_i.mode == bfi_pkg::MODE_COPY) begin
            state_d = bfi_pkg::ST_COPY_INIT;
          end else if (sts_i.mode == bfi_pkg::MODE_POPB) begin
            state_d = bfi_pkg::ST_POPB_RD;
          end else if (sts_i.mode == bfi_pkg::MODE_POPF || sts_i.mode == bfi_pkg::MODE_AND ||
                       sts_i.mode == bfi_pkg::MODE_OR || sts_i.mode == bfi_pkg::MODE_NZ ||
                       sts_i.mode == bfi_pkg::MODE_XOR) begin
            state_d = bfi_pkg::ST_POPF_RD;
          end
        end
      end
      bfi_pkg::ST_EXEC: begin
        cmd_o   = bfi_pkg::CMD_EXEC;
        state_d = bfi_pkg::ST_SETTLE;
      end
      bfi_pkg::ST_HALT: begin
        cmd_o   = bfi_pkg::CMD_HALT;
        state_d = bfi_pkg::ST_SETTLE;
      end
      bfi_pkg::ST_SCANF_INIT: begin
        cmd_o   = bfi_pkg::CMD_SCANF_INIT;
        state_d = sts_i.done ? bfi_pkg::ST_SETTLE : bfi_pkg::ST_SCANF_RD;
      end
      bfi_pkg::ST_SCANF_RD: begin
        cmd_o   = bfi_pkg::CMD_SCANF_RD;
        state_d = bfi_pkg::ST_SCANF_CHK;
      end
      bfi_pkg::ST_SCANF_CHK: begin
        cmd_o   = bfi_pkg::CMD_SCANF_CHK;
        state_d = sts_i.done ? bfi_pkg::ST_SETTLE : bfi_pkg::ST_SCANF_RD;
      end
      bfi_pkg::ST_SCANB_INIT: begin
        cmd_o   = bfi_pkg::CMD_SCANB_INIT;
        state_d = bfi_pkg::ST_SCANB_DEC;
      end
      bfi_pkg::ST_SCANB_DEC: begin
        cmd_o   = bfi_pkg::CMD_SCANB_DEC;
        state_d = sts_i.done ? bfi_pkg::ST_SETTLE : bfi_pkg::ST_SCANB_RD;
      end
      bfi_pkg::ST_SCANB_RD: begin
        cmd_o   = bfi_pkg::CMD_SCANB_RD;
        state_d = bfi_pkg::ST_SCANB_CHK;
      end
      bfi_pkg::ST_SCANB_CHK: begin
        cmd_o   = bfi_pkg::CMD_SCANB_CHK;
        state_d = sts_i.done ? bfi_pkg::ST_SETTLE : bfi_pkg::ST_SCANB_DEC;
      end
      bfi_pkg::ST_COPY_INIT: begin
        cmd_o   = bfi_pkg::CMD_COPY_INIT;
        state_d = bfi_pkg::ST_COPY_RD;
      end
      bfi_pkg::ST_COPY_RD: begin
        cmd_o   = bfi_pkg::CMD_COPY_RD;
        state_d = bfi_pkg::ST_COPY_CHK;
      end
      bfi_pkg::ST_COPY_CHK: begin
        cmd_o   = bfi_pkg::CMD_COPY_CHK;
        state_d = sts_i.done ? bfi_pkg::ST_ADVANCE : bfi_pkg::ST_COPY_RD;
      end
      bfi_pkg::ST_POPB_RD: begin
        cmd_o   = bfi_pkg::CMD_POPB_RD;
        state_d = bfi_pkg::ST_POPB_WR;
      end
      bfi_pkg::ST_POPB_WR: begin
        cmd_o   = bfi_pkg::CMD_POPB_WR;
        state_d = bfi_pkg::ST_ADVANCE;
      end
      bfi_pkg::ST_POPF_RD: begin
        cmd_o   = bfi_pkg::CMD_POPF_RD;
        state_d = bfi_pkg::ST_POPF_WR;
      end
      bfi_pkg::ST_POPF_WR: begin
        cmd_o   = bfi_pkg::CMD_POPF_WR;
        state_d = bfi_pkg::ST_ADVANCE;
      end
      bfi_pkg::ST_ADVANCE: begin
        cmd_o   = bfi_pkg::CMD_ADVANCE;
        state_d = bfi_pkg::ST_SETTLE;
      end
      bfi_pkg::ST_SETTLE: begin
        state_d = bfi_pkg::ST_OUT;
      end
      bfi_pkg::ST_OUT: begin
        strobe_o = 1'b1;
        state_d  = bfi_pkg::ST_IDLE;
      end
      default: begin
        state_d = bfi_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bfi_dpath.sv =====
// Datapath: machine registers, program/data/queue stores and instruction execution.
module bfi_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bfi_pkg::cmd_e     cmd_i,
  input  bfi_pkg::in_t      req_i,
  output bfi_pkg::ctl_sts_t sts_o,
  output bfi_pkg::out_t     res_o
);

  localparam int unsigned BW = bfi_pkg::BYTE_W;
  localparam int unsigned PW = bfi_pkg::PC_W;
  localparam int unsigned AW = bfi_pkg::PA_W;
  localparam int unsigned DW = bfi_pkg::DA_W;
  localparam int unsigned QA = bfi_pkg::QA_W;
  localparam int unsigned QC = bfi_pkg::QC_W;

  bfi_pkg::in_t req_q, req_d;
  logic [PW-1:0] pc_q, pc_d, s_q, s_d, depth_q, depth_d;
  logic [DW-1:0] dp_q, dp_d;
  logic [BW-1:0] mode_q, mode_d, instr_q, instr_d, cell_q, cell_d;
  logic          halted_q, halted_d, pe_q, pe_d;
  logic [QC-1:0] qcnt_q, qcnt_d;
  logic [QA-1:0] qhead_q, qhead_d;
  logic [bfi_pkg::PROG_DEPTH-1:0] prog_vld_q, prog_vld_d;
  logic [bfi_pkg::MEM_DEPTH-1:0]  data_vld_q, data_vld_d;
  logic          prog_vld_rd_q, data_vld_rd_q;

  logic          prog_we, data_we, q_we;
  logic [AW-1:0] prog_raddr;
  logic [BW-1:0] prog_rdata, data_rdata, q_rdata, data_wdata, q_wdata;
  logic [QA-1:0] q_waddr, q_raddr;
  logic [BW-1:0] prog_byte, cell_rd, pop_val;
  logic [PW-1:0] pc_inc, pc_mid, pc_nxt, s_inc, nd_fwd, nd_bwd, jf_sum;
  logic [QC-1:0] qcnt_m1;
  logic          is_lb, is_rb, done;

  assign prog_byte = prog_vld_rd_q ? prog_rdata : '0;
  assign cell_rd   = data_vld_rd_q ? data_rdata : '0;
  assign pop_val   = pe_q ? '0 : q_rdata;
  assign pc_inc    = pc_q + PW'(1);
  assign s_inc     = s_q + PW'(1);
  assign pc_nxt    = pc_mid + PW'(1);
  assign jf_sum    = pc_q + PW'(cell_q);
  assign qcnt_m1   = qcnt_q - QC'(1);
  assign is_lb     = (prog_byte == bfi_pkg::CH_LB);
  assign is_rb     = (prog_byte == bfi_pkg::CH_RB);
  assign nd_fwd    = depth_q + PW'(is_lb) - PW'(is_rb);
  assign nd_bwd    = depth_q + PW'(is_rb) - PW'(is_lb);

  assign prog_we    = (cmd_i == bfi_pkg::CMD_LOAD);
  assign prog_raddr = (cmd_i == bfi_pkg::CMD_SCANF_RD || cmd_i == bfi_pkg::CMD_SCANB_RD ||
                       cmd_i == bfi_pkg::CMD_COPY_RD) ? s_q[AW-1:0] : pc_q[AW-1:0];

  always_comb begin
    req_d      = req_q;
    pc_d       = pc_q;
    s_d        = s_q;
    depth_d    = depth_q;
    dp_d       = dp_q;
    mode_d     = mode_q;
    instr_d    = instr_q;
    cell_d     = cell_q;
    halted_d   = halted_q;
    pe_d       = pe_q;
    qcnt_d     = qcnt_q;
    qhead_d    = qhead_q;
    prog_vld_d = prog_vld_q;
    data_vld_d = data_vld_q;
    data_we    = 1'b0;
    data_wdata = cell_q;
    q_we       = 1'b0;
    q_waddr    = qhead_q + qcnt_q[QA-1:0];
    q_wdata    = cell_q;
    q_raddr    = qhead_q;
    pc_mid     = pc_q;
    done       = 1'b0;
    case (cmd_i)
      bfi_pkg::CMD_ACCEPT: req_d = req_i;
      bfi_pkg::CMD_LOAD:   prog_vld_d[req_q.prog_addr] = 1'b1;
      bfi_pkg::CMD_RESTART: begin
        pc_d       = '0;
        dp_d       = '0;
        mode_d     = '0;
        halted_d   = 1'b0;
        qcnt_d     = '0;
        qhead_d    = '0;
        data_vld_d = '0;
      end
      bfi_pkg::CMD_HALT: halted_d = 1'b1;
      bfi_pkg::CMD_DECODE: begin
        instr_d = prog_byte;
        cell_d  = cell_rd;
      end
      bfi_pkg::CMD_EXEC: begin
        case (instr_q)
          bfi_pkg::CH_RIGHT: if (dp_q != DW'(bfi_pkg::MEM_DEPTH - 1)) dp_d = dp_q + DW'(1);
          bfi_pkg::CH_LEFT:  if (dp_q != '0) dp_d = dp_q - DW'(1);
          bfi_pkg::CH_PLUS: begin
            data_we = 1'b1;
            if (cell_q != '1) data_wdata = cell_q + BW'(1);
          end
          bfi_pkg::CH_MINUS: begin
            data_we = 1'b1;
            if (cell_q != '0) data_wdata = cell_q - BW'(1);
          end
          bfi_pkg::CH_EQ: mode_d = cell_q;
          bfi_pkg::CH_IO: begin
            case (mode_q)
              bfi_pkg::MODE_PUSH: begin
                if (qcnt_q != QC'(bfi_pkg::Q_DEPTH)) begin
                  q_we   = 1'b1;
                  qcnt_d = qcnt_q + QC'(1);
                end
              end
              bfi_pkg::MODE_QCLR: begin
                qcnt_d  = '0;
                qhead_d = '0;
              end
              bfi_pkg::MODE_LOWER: begin
                data_we = 1'b1;
                if (cell_q <= bfi_pkg::LIM_LETTER) data_wdata = cell_q + bfi_pkg::OFS_LOWER;
              end
              bfi_pkg::MODE_UPPER: begin
                data_we = 1'b1;
                if (cell_q <= bfi_pkg::LIM_LETTER) data_wdata = cell_q + bfi_pkg::OFS_UPPER;
              end
              bfi_pkg::MODE_DIGIT: begin
                data_we = 1'b1;
                if (cell_q <= bfi_pkg::LIM_DIGIT) data_wdata = cell_q + bfi_pkg::OFS_DIGIT;
              end
              bfi_pkg::MODE_OPCODE: begin
                data_we = 1'b1;
                if (cell_q <= bfi_pkg::LIM_OPCODE) data_wdata = bfi_pkg::op_code(cell_q[2:0]);
              end
              bfi_pkg::MODE_RDDP: begin
                data_we    = 1'b1;
                data_wdata = BW'(dp_q);
              end
              bfi_pkg::MODE_RDPC: begin
                data_we    = 1'b1;
                data_wdata = pc_q[BW-1:0] + BW'(1);
              end
              bfi_pkg::MODE_JBACK: if (pc_q >= PW'(cell_q)) pc_mid = pc_q - PW'(cell_q);
              bfi_pkg::MODE_JFWD:  if (jf_sum < PW'(bfi_pkg::PROG_DEPTH)) pc_mid = jf_sum;
              default: ;
            endcase
          end
          default: ;
        endcase
        pc_d = pc_nxt;
        if (pc_nxt >= PW'(bfi_pkg::PROG_DEPTH)) halted_d = 1'b1;
      end
      bfi_pkg::CMD_ADVANCE: begin
        pc_d = pc_inc;
        if (pc_inc >= PW'(bfi_pkg::PROG_DEPTH)) halted_d = 1'b1;
      end
      bfi_pkg::CMD_SCANF_INIT: begin
        s_d     = pc_inc;
        depth_d = PW'(1);
        if (pc_inc >= PW'(bfi_pkg::PROG_DEPTH)) begin
          done     = 1'b1;
          pc_d     = pc_inc;
          halted_d = 1'b1;
        end
      end
      bfi_pkg::CMD_SCANF_CHK: begin
        depth_d = nd_fwd;
        if (nd_fwd == '0 || s_q == PW'(bfi_pkg::PROG_DEPTH - 1)) begin
          // match lands one past the bracket; no match runs off the end
          done = 1'b1;
          pc_d = s_inc;
          if (s_inc >= PW'(bfi_pkg::PROG_DEPTH)) halted_d = 1'b1;
        end else begin
          s_d = s_inc;
        end
      end
      bfi_pkg::CMD_SCANB_INIT: begin
        s_d     = pc_q;
        depth_d = PW'(1);
      end
      bfi_pkg::CMD_SCANB_DEC: begin
        if (s_q == '0) begin
          done = 1'b1;
          pc_d = PW'(1);
        end else begin
          s_d = s_q - PW'(1);
        end
      end
      bfi_pkg::CMD_SCANB_CHK: begin
        depth_d = nd_bwd;
        if (nd_bwd == '0) begin
          done = 1'b1;
          pc_d = s_inc;
        end
      end
      bfi_pkg::CMD_COPY_INIT: begin
        s_d     = '0;
        qcnt_d  = '0;
        qhead_d = '0;
      end
      bfi_pkg::CMD_COPY_CHK: begin
        q_we    = 1'b1;
        q_wdata = prog_byte;
        qcnt_d  = qcnt_q + QC'(1);
        if (prog_byte == bfi_pkg::CH_HALT || s_q == PW'(bfi_pkg::PROG_DEPTH - 1) ||
            qcnt_q == QC'(bfi_pkg::Q_DEPTH - 1)) begin
          done = 1'b1;
        end else begin
          s_d = s_inc;
        end
      end
      bfi_pkg::CMD_POPB_RD: begin
        pe_d = (qcnt_q == '0);
        if (qcnt_q != '0) begin
          qcnt_d  = qcnt_m1;
          q_raddr = qhead_q + qcnt_m1[QA-1:0];
        end
      end
      bfi_pkg::CMD_POPB_WR: begin
        data_we    = 1'b1;
        data_wdata = pop_val;
      end
      bfi_pkg::CMD_POPF_RD: begin
        pe_d = (qcnt_q == '0);
        if (qcnt_q != '0) begin
          qcnt_d  = qcnt_m1;
          qhead_d = qhead_q + QA'(1);
        end
      end
      bfi_pkg::CMD_POPF_WR: begin
        data_we = 1'b1;
        case (mode_q)
          bfi_pkg::MODE_AND: data_wdata = cell_q & pop_val;
          bfi_pkg::MODE_OR:  data_wdata = cell_q | pop_val;
          bfi_pkg::MODE_NZ:  data_wdata = (pop_val != '0) ? BW'(1) : '0;
          bfi_pkg::MODE_XOR: data_wdata = cell_q ^ pop_val;
          default:           data_wdata = pop_val;
        endcase
      end
      default: ;
    endcase
    if (data_we) data_vld_d[dp_q] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q          <= '0;
      dp_q          <= '0;
      mode_q        <= '0;
      halted_q      <= 1'b0;
      qcnt_q        <= '0;
      qhead_q       <= '0;
      prog_vld_q    <= '0;
      data_vld_q    <= '0;
      prog_vld_rd_q <= 1'b0;
      data_vld_rd_q <= 1'b0;
    end else begin
      pc_q          <= pc_d;
      dp_q          <= dp_d;
      mode_q        <= mode_d;
      halted_q      <= halted_d;
      qcnt_q        <= qcnt_d;
      qhead_q       <= qhead_d;
      prog_vld_q    <= prog_vld_d;
      data_vld_q    <= data_vld_d;
      prog_vld_rd_q <= prog_vld_q[prog_raddr];
      data_vld_rd_q <= data_vld_q[dp_q];
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    s_q     <= s_d;
    depth_q <= depth_d;
    instr_q <= instr_d;
    cell_q  <= cell_d;
    pe_q    <= pe_d;
  end

  bfi_ram #(.WIDTH(BW), .DEPTH(bfi_pkg::PROG_DEPTH)) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (req_q.prog_addr),
    .wdata_i (req_q.prog_byte),
    .raddr_i (prog_raddr),
    .rdata_o (prog_rdata)
  );

  bfi_ram #(.WIDTH(BW), .DEPTH(bfi_pkg::MEM_DEPTH)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (dp_q),
    .wdata_i (data_wdata),
    .raddr_i (dp_q),
    .rdata_o (data_rdata)
  );

  bfi_ram #(.WIDTH(BW), .DEPTH(bfi_pkg::Q_DEPTH)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  assign sts_o.stop      = halted_q | pc_q[PW-1];
  assign sts_o.done      = done;
  assign sts_o.cell_zero = (cell_rd == '0);
  assign sts_o.instr     = prog_byte;
  assign sts_o.mode      = mode_q;

  assign res_o.running         = ~halted_q;
  assign res_o.program_counter = pc_q;
  assign res_o.data_pointer    = dp_q;
  assign res_o.cell_value      = cell_rd;
  assign res_o.current_mode    = mode_q;
  assign res_o.queue_fill      = qcnt_q;

`ifndef ASSERT_OFF
  a_qcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcnt_q <= QC'(bfi_pkg::Q_DEPTH)) else $error("queue count overflow");
  a_pc_end_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q[PW-1] |-> halted_q) else $error("pc at end without halt");
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == bfi_pkg::CMD_RESTART |=> (pc_q == '0 && !halted_q && qcnt_q == '0 &&
                                       data_vld_q == '0)) else $error("restart incomplete");
`endif

endmodule

// ===== tb/sv/tb_bf_style_interpreter_step.sv =====
// Testbench for the stepping byte-code interpreter: directed and random programs against a predictor.
`timescale 1ns / 100ps
module tb_bf_style_interpreter_step;

  localparam int unsigned EXP_N = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  bfi_pkg::in_t req_i = '0;
  logic result_valid_o;
  bfi_pkg::out_t result_o;

  bf_style_interpreter_step dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .result_valid_o(result_valid_o), .result_o(result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [7:0] m_prog [bfi_pkg::PROG_DEPTH];
  logic [7:0] m_data [bfi_pkg::MEM_DEPTH];
  logic [7:0] m_queue [bfi_pkg::Q_DEPTH];
  int unsigned m_qcnt, m_qhead, m_pc, m_dp, m_mode;
  bit m_halted;
  bfi_pkg::out_t exp_buf [EXP_N];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;
  logic [7:0] pbuf [bfi_pkg::PROG_DEPTH];
  int unsigned plen = 0;
  int errors = 0;
  bit no_idle = 0;

  function automatic void mach_restart();
    foreach (m_data[i]) m_data[i] = 8'd0;
    m_qcnt = 0; m_qhead = 0; m_pc = 0; m_dp = 0; m_mode = 0; m_halted = 0;
  endfunction

  function automatic void q_push(logic [7:0] v);
    if (m_qcnt < bfi_pkg::Q_DEPTH) begin
      m_queue[(m_qhead + m_qcnt) % bfi_pkg::Q_DEPTH] = v;
      m_qcnt++;
    end
  endfunction

  function automatic logic [7:0] q_front();
    logic [7:0] v;
    if (m_qcnt == 0) return 8'd0;
    v = m_queue[m_qhead];
    m_qhead = (m_qhead + 1) % bfi_pkg::Q_DEPTH;
    m_qcnt--;
    return v;
  endfunction

  function automatic logic [7:0] q_back();
    if (m_qcnt == 0) return 8'd0;
    m_qcnt--;
    return m_queue[(m_qhead + m_qcnt) % bfi_pkg::Q_DEPTH];
  endfunction

  function automatic void do_io();
    logic [7:0] c;
    c = m_data[m_dp];
    case (m_mode[7:0])
      bfi_pkg::MODE_COPY: begin
        m_qcnt = 0; m_qhead = 0;
        for (int i = 0; i < bfi_pkg::PROG_DEPTH && m_qcnt < bfi_pkg::Q_DEPTH; i++) begin
          q_push(m_prog[i]);
          if (m_prog[i] == bfi_pkg::CH_HALT) break;
        end
      end
      bfi_pkg::MODE_PUSH: q_push(c);
      bfi_pkg::MODE_POPB: c = q_back();
      bfi_pkg::MODE_POPF: c = q_front();
      bfi_pkg::MODE_QCLR: begin m_qcnt = 0; m_qhead = 0; end
      bfi_pkg::MODE_LOWER: if (c <= bfi_pkg::LIM_LETTER) c = c + bfi_pkg::OFS_LOWER;
      bfi_pkg::MODE_UPPER: if (c <= bfi_pkg::LIM_LETTER) c = c + bfi_pkg::OFS_UPPER;
      bfi_pkg::MODE_DIGIT: if (c <= bfi_pkg::LIM_DIGIT) c = c + bfi_pkg::OFS_DIGIT;
      bfi_pkg::MODE_OPCODE: begin
        case (c)
          8'd0: c = bfi_pkg::CH_PLUS;  8'd1: c = bfi_pkg::CH_MINUS;
          8'd2: c = bfi_pkg::CH_LEFT;  8'd3: c = bfi_pkg::CH_RIGHT;
          8'd4: c = bfi_pkg::CH_LB;    8'd5: c = bfi_pkg::CH_RB;
          8'd6: c = bfi_pkg::CH_EQ;    8'd7: c = bfi_pkg::CH_IO;
          default: ;
        endcase
      end
      bfi_pkg::MODE_AND: c = c & q_front();
      bfi_pkg::MODE_OR:  c = c | q_front();
      bfi_pkg::MODE_NZ:  c = (q_front() != 8'd0) ? 8'd1 : 8'd0;
      bfi_pkg::MODE_XOR: c = c ^ q_front();
      bfi_pkg::MODE_RDDP: c = m_dp[7:0];
      bfi_pkg::MODE_RDPC: c = 8'(m_pc + 1);
      bfi_pkg::MODE_JBACK: if (m_pc >= c) m_pc -= c;
      bfi_pkg::MODE_JFWD: if (m_pc + c < bfi_pkg::PROG_DEPTH) m_pc += c;
      default: ;
    endcase
    m_data[m_dp] = c;
  endfunction

  function automatic void mach_exec();
    logic [7:0] c;
    int unsigned s, depth;
    if (m_halted || m_pc >= bfi_pkg::PROG_DEPTH) begin m_halted = 1; return; end
    c = m_data[m_dp];
    case (m_prog[m_pc])
      bfi_pkg::CH_RIGHT: if (m_dp + 1 < bfi_pkg::MEM_DEPTH) m_dp++;
      bfi_pkg::CH_LEFT:  if (m_dp != 0) m_dp--;
      bfi_pkg::CH_PLUS:  if (c != 8'hFF) m_data[m_dp] = 8'(c + 8'd1);
      bfi_pkg::CH_MINUS: if (c != 8'h00) m_data[m_dp] = 8'(c - 8'd1);
      bfi_pkg::CH_LB: if (c == 8'd0) begin
        depth = 1;
        for (s = m_pc + 1; s < bfi_pkg::PROG_DEPTH; s++) begin
          if (m_prog[s] == bfi_pkg::CH_LB) depth++;
          if (m_prog[s] == bfi_pkg::CH_RB) depth--;
          if (depth == 0) break;
        end
        if (s >= bfi_pkg::PROG_DEPTH) begin
          m_pc = bfi_pkg::PROG_DEPTH; m_halted = 1; return;
        end
        m_pc = s;
      end
      bfi_pkg::CH_RB: if (c != 8'd0) begin
        depth = 1; s = m_pc;
        while (s > 0) begin
          s--;
          if (m_prog[s] == bfi_pkg::CH_RB) depth++;
          if (m_prog[s] == bfi_pkg::CH_LB) depth--;
          if (depth == 0) break;
        end
        m_pc = s;
      end
      bfi_pkg::CH_EQ: m_mode = c;
      bfi_pkg::CH_IO: do_io();
      bfi_pkg::CH_HALT: begin m_halted = 1; return; end
      default: ;
    endcase
    m_pc++;
    if (m_pc >= bfi_pkg::PROG_DEPTH) begin m_pc = bfi_pkg::PROG_DEPTH; m_halted = 1; end
  endfunction

  function automatic void predict_state(bfi_pkg::in_t r);
    bfi_pkg::out_t o;
    case (r.req_type)
      bfi_pkg::REQ_LOAD: m_prog[r.prog_addr] = r.prog_byte;
      bfi_pkg::REQ_EXEC: mach_exec();
      bfi_pkg::REQ_RESTART: mach_restart();
      default: ;
    endcase
    o.running = !m_halted;
    o.program_counter = m_pc[bfi_pkg::PC_W-1:0];
    o.data_pointer = m_dp[bfi_pkg::DA_W-1:0];
    o.cell_value = m_data[m_dp];
    o.current_mode = m_mode[7:0];
    o.queue_fill = m_qcnt[bfi_pkg::QC_W-1:0];
    exp_buf[exp_wr % EXP_N] = o;
    exp_wr++;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    bfi_pkg::out_t e;
    if (result_valid_o) begin
      if (exp_wr == exp_rd) report_mismatch("unexpected result", 1, 0);
      else begin
        e = exp_buf[exp_rd % EXP_N];
        exp_rd++;
        if (result_o.running !== e.running)
          report_mismatch("running", result_o.running, e.running);
        if (result_o.program_counter !== e.program_counter)
          report_mismatch("program_counter", result_o.program_counter, e.program_counter);
        if (result_o.data_pointer !== e.data_pointer)
          report_mismatch("data_pointer", result_o.data_pointer, e.data_pointer);
        if (result_o.cell_value !== e.cell_value)
          report_mismatch("cell_value", result_o.cell_value, e.cell_value);
        if (result_o.current_mode !== e.current_mode)
          report_mismatch("current_mode", result_o.current_mode, e.current_mode);
        if (result_o.queue_fill !== e.queue_fill)
          report_mismatch("queue_fill", result_o.queue_fill, e.queue_fill);
      end
    end
  end

  task automatic send(logic [1:0] kind, logic [7:0] addr = 8'd0, logic [7:0] data = 8'd0);
    bfi_pkg::in_t r;
    @(posedge clk_i);
    if (!no_idle)
      while ($urandom_range(99) < 18) @(posedge clk_i);
    r.req_type = kind; r.prog_addr = addr; r.prog_byte = data;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predict_state(r);
    start <= 1'b0;
  endtask

  function automatic void prog_clear();
    plen = 0;
  endfunction

  function automatic void add_op(logic [7:0] v);
    if (plen < bfi_pkg::PROG_DEPTH) begin
      pbuf[plen] = v;
      plen++;
    end
  endfunction

  task automatic load_prog();
    for (int unsigned i = 0; i < plen; i++) send(bfi_pkg::REQ_LOAD, 8'(i), pbuf[i]);
    for (int unsigned i = plen; i < plen + 2 && i < bfi_pkg::PROG_DEPTH; i++)
      send(bfi_pkg::REQ_LOAD, 8'(i), bfi_pkg::CH_HALT);
  endtask

  task automatic wait_drain();
    while (exp_wr != exp_rd) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_op();
    int k;
    k = $urandom_range(99);
    if (k < 16) return bfi_pkg::CH_PLUS;
    if (k < 24) return bfi_pkg::CH_MINUS;
    if (k < 34) return bfi_pkg::CH_RIGHT;
    if (k < 42) return bfi_pkg::CH_LEFT;
    if (k < 48) return bfi_pkg::CH_LB;
    if (k < 54) return bfi_pkg::CH_RB;
    if (k < 68) return bfi_pkg::CH_EQ;
    if (k < 92) return bfi_pkg::CH_IO;
    if (k < 94) return bfi_pkg::CH_HALT;
    return 8'($urandom_range(255));
  endfunction

  task automatic test_directed();
    send(bfi_pkg::REQ_EXEC);
    send(2'd3);
    send(bfi_pkg::REQ_LOAD, 8'd255, 8'hFF);
    send(bfi_pkg::REQ_LOAD, 8'd255, bfi_pkg::CH_HALT);
    send(bfi_pkg::REQ_RESTART);
    // pointer and cell saturation at zero, a backward bracket loop
    prog_clear();
    add_op(bfi_pkg::CH_LEFT); add_op(bfi_pkg::CH_MINUS); add_op(bfi_pkg::CH_EQ);
    add_op(bfi_pkg::CH_IO);   add_op(bfi_pkg::CH_RIGHT); add_op(bfi_pkg::CH_PLUS);
    add_op(bfi_pkg::CH_LB);   add_op(bfi_pkg::CH_RB);
    load_prog();
    repeat (10) send(bfi_pkg::REQ_EXEC);
    send(bfi_pkg::REQ_RESTART);
    // unmatched forward bracket runs off the end
    send(bfi_pkg::REQ_LOAD, 8'd0, bfi_pkg::CH_LB);
    send(bfi_pkg::REQ_LOAD, 8'd1, bfi_pkg::CH_LB);
    send(bfi_pkg::REQ_EXEC); send(bfi_pkg::REQ_EXEC);
  endtask

  // Programs that mostly build a mode value, set it, then do I/O, followed by random content
  task automatic test_programs(int n_items);
    int unsigned len, mode, steps, sent;
    sent = 0;
    while (sent < n_items) begin
      prog_clear();
      if ($urandom_range(9) < 7) begin
        repeat ($urandom_range(6)) begin
          mode = $urandom_range(5) == 0 ? $urandom_range(255) : $urandom_range(6, 27);
          add_op(bfi_pkg::CH_RIGHT);
          repeat (mode > 40 ? 3 : mode) add_op(bfi_pkg::CH_PLUS);
          add_op(bfi_pkg::CH_EQ);
          add_op(bfi_pkg::CH_LEFT);
          repeat ($urandom_range(1, 4)) begin
            add_op(bfi_pkg::CH_PLUS);
            add_op(bfi_pkg::CH_IO);
          end
          if ($urandom_range(3) == 0) add_op(bfi_pkg::CH_MINUS);
          if ($urandom_range(3) == 0) add_op(bfi_pkg::CH_IO);
        end
        if ($urandom_range(2) == 0) begin
          add_op(bfi_pkg::CH_PLUS); add_op(bfi_pkg::CH_PLUS); add_op(bfi_pkg::CH_LB);
          add_op(bfi_pkg::CH_MINUS); add_op(bfi_pkg::CH_RB);
        end
      end
      len = $urandom_range(1, 40);
      while (plen < len) add_op(rand_op());
      if ($urandom_range(15) == 0) while (plen < bfi_pkg::PROG_DEPTH) add_op(rand_op());
      send(bfi_pkg::REQ_RESTART);
      load_prog();
      sent += plen + 3;
      steps = $urandom_range(plen, 3 * plen + 10);
      repeat (steps) send(bfi_pkg::REQ_EXEC);
      sent += steps;
      if ($urandom_range(15) == 0)
        send(bfi_pkg::REQ_LOAD, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endtask

  task automatic test_pause();
    wait_drain();
    repeat (10) @(posedge clk_i);
    send(bfi_pkg::REQ_EXEC);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    mach_restart();
    foreach (m_prog[i]) m_prog[i] = bfi_pkg::CH_HALT;
    @(posedge clk_i);
    test_directed();
    test_pause();
    test_programs(900);
    no_idle = 1;
    test_programs(300);
    no_idle = 0;
    test_programs(700);
    wait_drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #200ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/bfi_pkg.sv
rtl/bfi_ram.sv
rtl/bfi_ctrl.sv
rtl/bfi_dpath.sv
rtl/bf_style_interpreter_step.sv
tb/sv/tb_bf_style_interpreter_step.sv
